// ===== hdl/ncc_pkg.sv =====
// Package for the normalized cross-correlation block.
// Shared widths, reset values and limits. No dependencies.
`default_nettype none
package ncc_pkg;
    localparam int COUNT_BITS_DEF = 22;
    localparam int PIX_W          = 8;
    localparam int CFG_W          = 10;
    localparam int CORR_W         = 16;
    localparam int PCNT_W         = 22;
    localparam int Q_W            = 15;
    localparam int ODD_W          = 16;
    localparam int ODD2_W         = 32;
    localparam int QUEUE_DEPTH    = 2;
    // Snapshot holds count, two linear sums and three quadratic sums
    localparam int SNAP_EXTRA     = 64;

    localparam logic [CFG_W-1:0]  MIN_PAIR_RESET = CFG_W'(10);
    localparam logic [PCNT_W-1:0] PAIR_COUNT_MAX = '1;
    localparam logic [Q_W-1:0]    Q15_MAX        = '1;
endpackage
`default_nettype wire

// ===== hdl/ncc_fifo.sv =====
// Short queue of finished sum snapshots between front and back.
// Register based; depends on nothing.
`default_nettype none
module ncc_fifo #(
    parameter int W     = 196,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_avail
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ncc_front.sv =====
// Front end: accumulates pair count and moment sums, one pair a cycle while
// the queue has room. Pushes a snapshot to the queue on the last pair. Uses ncc_pkg.
`default_nettype none
module ncc_front #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ncc_pkg::PIX_W-1:0]       i_template_pixel,
    input  wire logic [ncc_pkg::PIX_W-1:0]       i_target_pixel,
    input  wire logic                            i_in_bounds,
    input  wire logic                            i_last_pair,
    output logic                                 o_push,
    output logic [6*COUNT_BITS+ncc_pkg::SNAP_EXTRA-1:0] o_data,
    input  wire logic                            i_full
);
    import ncc_pkg::*;

    localparam int SW = COUNT_BITS + 8;
    localparam int QW = COUNT_BITS + 16;

    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [SW-1:0]         r_sa, n_sa, r_sb, n_sb;
    logic [QW-1:0]         r_saa, n_saa, r_sbb, n_sbb, r_sab, n_sab;
    logic                  accept;
    logic                  take;
    logic [2*PIX_W-1:0]    aa, bb, ab;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    // Hold everything once the count is full so the sums never wrap
    assign take    = accept && i_in_bounds && (r_cnt != '1);

    assign aa = (2*PIX_W)'(i_template_pixel) * (2*PIX_W)'(i_template_pixel);
    assign bb = (2*PIX_W)'(i_target_pixel) * (2*PIX_W)'(i_target_pixel);
    assign ab = (2*PIX_W)'(i_template_pixel) * (2*PIX_W)'(i_target_pixel);

    always_comb begin
        n_cnt = r_cnt;
        n_sa  = r_sa;
        n_sb  = r_sb;
        n_saa = r_saa;
        n_sbb = r_sbb;
        n_sab = r_sab;
        if (take) begin
            n_cnt = r_cnt + 1'b1;
            n_sa  = r_sa + SW'(i_template_pixel);
            n_sb  = r_sb + SW'(i_target_pixel);
            n_saa = r_saa + QW'(aa);
            n_sbb = r_sbb + QW'(bb);
            n_sab = r_sab + QW'(ab);
        end
    end

    assign o_push = accept && i_last_pair;
    assign o_data = {n_cnt, n_sa, n_saa, n_sb, n_sbb, n_sab};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_saa <= '0;
            r_sbb <= '0;
            r_sab <= '0;
        end else if (accept) begin
            if (i_last_pair) begin
                r_cnt <= '0;
                r_sa  <= '0;
                r_sb  <= '0;
                r_saa <= '0;
                r_sbb <= '0;
                r_sab <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_sa  <= n_sa;
                r_sb  <= n_sb;
                r_saa <= n_saa;
                r_sbb <= n_sbb;
                r_sab <= n_sab;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ncc_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, stops early when
// the remaining multiplier bits are zero. Uses ncc_pkg.
`default_nettype none
module ncc_mul #(
    parameter int MC_W = 120,
    parameter int MP_W = 60
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [MC_W-1:0]                 i_mcand,
    input  wire logic [MP_W-1:0]                 i_mplier,
    output logic [MC_W+ncc_pkg::ODD2_W-1:0]      o_prod,
    output logic                                 o_busy,
    output logic                                 o_done
);
    import ncc_pkg::*;

    localparam int RW = MC_W + ODD2_W;

    logic [RW-1:0]   r_acc;
    logic [RW-1:0]   r_mc;
    logic [MP_W-1:0] r_mp;
    logic            r_busy;
    logic            r_done;

    assign o_prod = r_acc;
    assign o_busy = r_busy;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_mp == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= RW'(i_mcand);
            r_mp  <= i_mplier;
        end else if (r_busy && (r_mp != '0)) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[RW-2:0], 1'b0};
            r_mp <= r_mp >> 1;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ncc_back.sv =====
// Back end: per snapshot, forms variances, covariance and the Q1.15
// coefficient by bisection over a shared shift-add multiplier.
// Holds the output register. Uses ncc_pkg and ncc_mul.
`default_nettype none
module ncc_back #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic [6*COUNT_BITS+ncc_pkg::SNAP_EXTRA-1:0] i_data,
    input  wire logic                                    i_avail,
    output logic                                         o_pop,
    input  wire logic [ncc_pkg::CFG_W-1:0]               i_min_pair_count,
    output logic                                         o_valid,
    input  wire logic                                    i_out_ready,
    output logic signed [ncc_pkg::CORR_W-1:0]            o_correlation,
    output logic                                         o_result_valid,
    output logic [ncc_pkg::PCNT_W-1:0]                   o_pair_count
);
    import ncc_pkg::*;

    localparam int C  = COUNT_BITS;
    localparam int SW = C + 8;
    localparam int QW = C + 16;
    localparam int VW = 2*C + 16;
    localparam int PW = 2*VW;
    localparam int RW = PW + ODD2_W;
    localparam int NW = (C > PCNT_W) ? C : PCNT_W;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_GO, S_EMIT} t_state;
    typedef enum logic [3:0] {
        ST_NSAA, ST_SASA, ST_NSBB, ST_SBSB, ST_PROD,
        ST_NSAB, ST_SASB, ST_NUM2, ST_SRCH
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [C-1:0]  s_cnt;
    logic [SW-1:0] s_sa, s_sb;
    logic [QW-1:0] s_saa, s_sbb, s_sab;

    logic [C-1:0]      r_n;
    logic [SW-1:0]     r_sa, r_sb;
    logic [QW-1:0]     r_sbb, r_sab;
    logic [VW-1:0]     r_va, r_vb;
    logic [PW-1:0]     r_prod;
    logic [RW-1:0]     r_rhs;
    logic              r_neg;
    logic              r_res_ok;
    logic [Q_W-1:0]    r_lo, r_hi, r_mid;
    logic [ODD2_W-1:0] r_odd2;

    logic              r_mul_start;
    logic [PW-1:0]     r_mcand;
    logic [VW-1:0]     r_mplier;
    logic [RW-1:0]     mul_prod;
    logic              mul_busy;
    logic              mul_done;

    logic                     r_out_valid;
    logic signed [CORR_W-1:0] r_corr;
    logic                     r_res_valid;
    logic [PCNT_W-1:0]        r_pcnt;

    logic [VW-1:0]     prod_v;
    logic [VW-1:0]     vb_fin;
    logic              p_neg;
    logic [VW-1:0]     num;
    logic [Q_W-1:0]    mid_w;
    logic [ODD_W-1:0]  odd_w;
    logic [ODD2_W-1:0] odd2_w;
    logic [NW-1:0]     n_ext;
    logic [PCNT_W-1:0] pcnt_sat;
    logic [CORR_W-1:0] mag;

    assign {s_cnt, s_sa, s_saa, s_sb, s_sbb, s_sab} = i_data;
    assign o_pop = (r_state == S_IDLE) && i_avail;

    assign prod_v = VW'(mul_prod);
    assign vb_fin = r_vb - prod_v;
    assign p_neg  = (r_va < prod_v);
    assign num    = p_neg ? (prod_v - r_va) : (r_va - prod_v);
    assign mid_w  = Q_W'((17'(r_lo) + 17'(r_hi) + 17'd1) >> 1);
    assign odd_w  = {mid_w, 1'b0} - ODD_W'(1);
    assign odd2_w = ODD2_W'(odd_w) * ODD2_W'(odd_w);
    assign n_ext  = NW'(r_n);
    assign pcnt_sat = (n_ext > NW'(PAIR_COUNT_MAX)) ? PAIR_COUNT_MAX : PCNT_W'(n_ext);
    assign mag    = CORR_W'(r_lo);

    ncc_mul #(.MC_W(PW), .MP_W(VW)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_mcand  (r_mcand),
        .i_mplier (r_mplier),
        .o_prod   (mul_prod),
        .o_busy   (mul_busy),
        .o_done   (mul_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_NSAA;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_res_ok    <= 1'b0;
            r_neg       <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_mid       <= '0;
        end else begin
            r_mul_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_n   <= s_cnt;
                        r_sa  <= s_sa;
                        r_sb  <= s_sb;
                        r_sbb <= s_sbb;
                        r_sab <= s_sab;
                        r_neg <= 1'b0;
                        r_lo  <= '0;
                        r_hi  <= '0;
                        if (NW'(s_cnt) < NW'(i_min_pair_count)) begin
                            r_res_ok <= 1'b0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_mcand     <= PW'(s_saa);
                            r_mplier    <= VW'(s_cnt);
                            r_mul_start <= 1'b1;
                            r_step      <= ST_NSAA;
                            r_state     <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_mul_start <= 1'b1;
                        case (r_step)
                            ST_NSAA: begin
                                r_va     <= prod_v;
                                r_mcand  <= PW'(r_sa);
                                r_mplier <= VW'(r_sa);
                                r_step   <= ST_SASA;
                            end
                            ST_SASA: begin
                                r_va     <= r_va - prod_v;
                                r_mcand  <= PW'(r_sbb);
                                r_mplier <= VW'(r_n);
                                r_step   <= ST_NSBB;
                            end
                            ST_NSBB: begin
                                r_vb     <= prod_v;
                                r_mcand  <= PW'(r_sb);
                                r_mplier <= VW'(r_sb);
                                r_step   <= ST_SBSB;
                            end
                            ST_SBSB: begin
                                r_mcand  <= PW'(r_va);
                                r_mplier <= vb_fin;
                                r_step   <= ST_PROD;
                            end
                            ST_PROD: begin
                                r_prod <= PW'(mul_prod);
                                if (PW'(mul_prod) == '0) begin
                                    // flat image: no correlation
                                    r_mul_start <= 1'b0;
                                    r_res_ok    <= 1'b0;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_mcand  <= PW'(r_sab);
                                    r_mplier <= VW'(r_n);
                                    r_step   <= ST_NSAB;
                                end
                            end
                            ST_NSAB: begin
                                r_va     <= prod_v;
                                r_mcand  <= PW'(r_sb);
                                r_mplier <= VW'(r_sa);
                                r_step   <= ST_SASB;
                            end
                            ST_SASB: begin
                                r_neg    <= p_neg;
                                r_mcand  <= PW'(num);
                                r_mplier <= num;
                                r_step   <= ST_NUM2;
                            end
                            ST_NUM2: begin
                                r_mul_start <= 1'b0;
                                r_rhs   <= {PW'(mul_prod), ODD2_W'(0)};
                                r_lo    <= '0;
                                r_hi    <= Q15_MAX;
                                r_state <= S_CHK;
                            end
                            ST_SRCH: begin
                                r_mul_start <= 1'b0;
                                if (mul_prod <= r_rhs) begin
                                    r_lo <= r_mid;
                                end else begin
                                    r_hi <= r_mid - 1'b1;
                                end
                                r_state <= S_CHK;
                            end
                            default: begin
                                r_mul_start <= 1'b0;
                                r_state     <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    // bisect for the largest q with (2q-1)^2 * prod <= 2^32 * num^2
                    if (r_lo < r_hi) begin
                        r_mid   <= mid_w;
                        r_odd2  <= odd2_w;
                        r_state <= S_GO;
                    end else begin
                        r_res_ok <= 1'b1;
                        r_state  <= S_EMIT;
                    end
                end
                S_GO: begin
                    r_mcand     <= r_prod;
                    r_mplier    <= VW'(r_odd2);
                    r_mul_start <= 1'b1;
                    r_step      <= ST_SRCH;
                    r_state     <= S_MUL;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_res_valid <= r_res_ok;
                        r_pcnt      <= pcnt_sat;
                        if (!r_res_ok) begin
                            r_corr <= '0;
                        end else if (r_neg) begin
                            r_corr <= CORR_W'(0) - mag;
                        end else begin
                            r_corr <= mag;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_correlation  = r_corr;
    assign o_result_valid = r_res_valid;
    assign o_pair_count   = r_pcnt;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier result arrived outside a multiply step");

    a_bisect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("bisection bounds crossed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res_valid) |-> (r_corr == '0))
        else $error("invalid result carries a nonzero coefficient");
endmodule
`default_nettype wire

// ===== hdl/normalized_cross_correlation.sv =====
// Normalized cross-correlation of a stream of 8-bit pixel pairs.
// Input channel (i_valid/o_ready) takes one pair a cycle: template and
// target pixel, an in-bounds flag and a last-pair flag. Counted pairs add
// to the pair count and the moment sums; the last pair closes one
// evaluation and its sums move to a two-entry queue, after which the
// accumulators start again from zero.
// The back end turns each evaluation into one request on the output
// channel (o_valid/i_ready): Pearson coefficient in signed Q1.15, a valid
// flag and the saturated pair count. It runs one shift-add multiplier,
// one multiplier bit a cycle: eight products for the moments and then up
// to 15 bisection steps per evaluation, fewer when too few pairs were
// counted or the image is flat. The input keeps streaming while the
// queue has room.
// If the receiver stalls, the finished request holds in the output
// register, the back end waits with the next one, and once the queue is
// full o_ready drops. Reset clears the sums, queue and output valid and sets
// min_pair_count to 10; i_cfg_we writes it in the same cycle.
`default_nettype none
module normalized_cross_correlation #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [ncc_pkg::PIX_W-1:0]         i_template_pixel,
    input  wire logic [ncc_pkg::PIX_W-1:0]         i_target_pixel,
    input  wire logic                              i_in_bounds,
    input  wire logic                              i_last_pair,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [ncc_pkg::CORR_W-1:0]      o_correlation,
    output logic                                   o_result_valid,
    output logic [ncc_pkg::PCNT_W-1:0]             o_pair_count,
    input  wire logic                              i_cfg_we,
    input  wire logic [ncc_pkg::CFG_W-1:0]         i_cfg_data
);
    import ncc_pkg::*;

    localparam int SNAP_W = 6*COUNT_BITS + SNAP_EXTRA;

    logic [CFG_W-1:0]  r_min_pair_count;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_avail;
    logic [SNAP_W-1:0] q_in;
    logic [SNAP_W-1:0] q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pair_count <= MIN_PAIR_RESET;
        end else if (i_cfg_we) begin
            r_min_pair_count <= i_cfg_data;
        end
    end

    ncc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_template_pixel (i_template_pixel),
        .i_target_pixel   (i_target_pixel),
        .i_in_bounds      (i_in_bounds),
        .i_last_pair      (i_last_pair),
        .o_push           (q_push),
        .o_data           (q_in),
        .i_full           (q_full)
    );

    ncc_fifo #(.W(SNAP_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_avail (q_avail)
    );

    ncc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data           (q_out),
        .i_avail          (q_avail),
        .o_pop            (q_pop),
        .i_min_pair_count (r_min_pair_count),
        .o_valid          (o_valid),
        .i_out_ready      (i_ready),
        .o_correlation    (o_correlation),
        .o_result_valid   (o_result_valid),
        .o_pair_count     (o_pair_count)
    );
endmodule
`default_nettype wire
